FILE: rtl/core/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the bounding box and sphere accumulator.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int COORD_W    = 32;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int REM_W      = COORD_W + 2;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int CNT_W      = 5;
    localparam int IN_DATA_W  = AXES * COORD_W;
    localparam int OUT_DATA_W = (3 * AXES + 1) * COORD_W;

    localparam logic [AXIS_W-1:0] MUL_LAST  = AXIS_W'(AXES - 1);
    localparam logic [CNT_W-1:0]  ROOT_LAST = CNT_W'(SQRT_STEPS - 1);

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic              center_ld;
        logic              acc_clr;
        logic              mul_en;
        logic [AXIS_W-1:0] mul_sel;
        logic              acc_en;
        logic              root_init;
        logic              root_step;
        logic              out_load;
    } t_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/aabb_ctrl.sv
// ----------------------------------------------------------------------------
// aabb_ctrl
// Sequencer: accepts vertices, then steps center, squares, root and output.
// ----------------------------------------------------------------------------
module aabb_ctrl
    import aabb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_ACC,
        ST_CENTER,
        ST_MUL,
        ST_ADD,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_ACC: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ST_CENTER;
                end
            end
            ST_CENTER: begin
                n_state = ST_MUL;
                n_cnt   = '0;
            end
            ST_MUL: begin
                if (r_cnt[AXIS_W-1:0] == MUL_LAST) begin
                    n_state = ST_ADD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ADD: begin
                n_state = ST_ROOT_INIT;
            end
            ST_ROOT_INIT: begin
                n_state = ST_ROOT;
                n_cnt   = '0;
            end
            ST_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_sel   = r_cnt[AXIS_W-1:0];
        o_cmd.center_ld = (r_state == ST_CENTER);
        o_cmd.acc_clr   = (r_state == ST_CENTER);
        o_cmd.mul_en    = (r_state == ST_MUL);
        o_cmd.acc_en    = (r_state == ST_MUL) || (r_state == ST_ADD);
        o_cmd.root_init = (r_state == ST_ROOT_INIT);
        o_cmd.root_step = (r_state == ST_ROOT);
        o_cmd.out_load  = (r_state == ST_DONE) && i_sts.out_free;
    end

    assign o_in_ready = (r_state == ST_ACC);

    // a closing vertex must stop intake on the next cycle
    a_last_stops_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("intake still open after closing vertex");

endmodule

FILE: rtl/core/aabb_dp.sv
// ----------------------------------------------------------------------------
// aabb_dp
// Datapath: running min/max box, center, squared radius and bit-serial root.
// ----------------------------------------------------------------------------
module aabb_dp
    import aabb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_accept,
    input  logic                  i_first,
    input  logic [IN_DATA_W-1:0]  i_vertex,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    t_coord r_min [AXES];
    t_coord r_max [AXES];
    t_coord r_ctr [AXES];
    logic [COORD_W-1:0] r_mag [AXES];

    logic [SQ_W-1:0]    r_prod;
    logic [SQ_W-1:0]    r_sq;
    logic [SQ_W-1:0]    r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [COORD_W-1:0] r_root;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_coord             w_vtx  [AXES];
    t_coord             w_bmin [AXES];
    t_coord             w_bmax [AXES];
    logic signed [COORD_W:0] w_sum [AXES];
    t_coord             w_ctr  [AXES];
    logic signed [COORD_W:0] w_dist [AXES];
    logic [COORD_W:0]   w_abs  [AXES];
    logic [COORD_W-1:0] w_mul_op;
    logic [REM_W+1:0]   w_rem_sh;
    logic [REM_W+1:0]   w_trial;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_vtx[i]  = t_coord'(i_vertex[i*COORD_W +: COORD_W]);
            w_bmin[i] = i_first ? COORD_MAX : r_min[i];
            w_bmax[i] = i_first ? COORD_MIN : r_max[i];
            // floor of half sum at one extra bit, cannot overflow
            w_sum[i]  = {r_min[i][COORD_W-1], r_min[i]} + {r_max[i][COORD_W-1], r_max[i]};
            w_ctr[i]  = t_coord'(w_sum[i][COORD_W:1]);
            w_dist[i] = {r_max[i][COORD_W-1], r_max[i]} - {w_ctr[i][COORD_W-1], w_ctr[i]};
            w_abs[i]  = w_dist[i][COORD_W] ? (COORD_W+1)'(-w_dist[i])
                                           : (COORD_W+1)'(w_dist[i]);
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            2'd0:    w_mul_op = r_mag[0];
            2'd1:    w_mul_op = r_mag[1];
            2'd2:    w_mul_op = r_mag[2];
            default: w_mul_op = '0;
        endcase
    end

    assign w_rem_sh = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};

    // box corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_min[i] <= COORD_MAX;
                r_max[i] <= COORD_MIN;
            end
        end else if (i_in_accept) begin
            for (int i = 0; i < AXES; i++) begin
                r_min[i] <= (w_vtx[i] < w_bmin[i]) ? w_vtx[i] : w_bmin[i];
                r_max[i] <= (w_vtx[i] > w_bmax[i]) ? w_vtx[i] : w_bmax[i];
            end
        end
    end

    // center, squares and root
    always_ff @(posedge i_clk) begin
        if (i_cmd.center_ld) begin
            for (int i = 0; i < AXES; i++) begin
                r_ctr[i] <= w_ctr[i];
                // magnitude stays within 2^31 for a non-empty box
                r_mag[i] <= w_abs[i][COORD_W-1:0];
            end
        end
        if (i_cmd.acc_clr) begin
            r_prod <= '0;
            r_sq   <= '0;
        end else begin
            if (i_cmd.mul_en) begin
                r_prod <= SQ_W'(w_mul_op) * SQ_W'(w_mul_op);
            end else if (i_cmd.acc_en) begin
                r_prod <= '0;
            end
            if (i_cmd.acc_en) begin
                r_sq <= r_sq + r_prod;
            end
        end
        if (i_cmd.root_init) begin
            r_rad  <= r_sq;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= REM_W'(w_rem_sh - w_trial);
                r_root <= {r_root[COORD_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[REM_W-1:0];
                r_root <= {r_root[COORD_W-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_root,
                           r_ctr[2], r_ctr[1], r_ctr[0],
                           r_max[2], r_max[1], r_max[0],
                           r_min[2], r_min[1], r_min[0]};
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_in_accept && i_rst_n) |->
            (r_min[0] <= r_max[0]) && (r_min[1] <= r_max[1]) && (r_min[2] <= r_max[2]))
        else $error("box minimum above maximum after a vertex");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.center_ld, i_cmd.mul_en, i_cmd.root_init,
                  i_cmd.root_step, i_cmd.out_load}))
        else $error("overlapping datapath phases");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

    a_no_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_accept |-> !(i_cmd.mul_en || i_cmd.root_step || i_cmd.center_ld))
        else $error("vertex taken while result is being computed");

endmodule

FILE: rtl/core/aabb_vertex_accumulator.sv
// From the transfer of a vertex with tlast to m_axis_tvalid, the sequencer runs
// center, three squares, sum, root setup, 32 root steps and output load.
// Throughput: one vertex per cycle inside a set; each closing vertex stalls
// intake while the bit-serial square root runs, and longer if the previous
// result is still waiting. Synchronous active-low reset empties the box
// (min at most positive, max at most negative) and clears the output valid.
// ----------------------------------------------------------------------------
// aabb_vertex_accumulator
// Running axis-aligned bounding box of a vertex stream, with center and radius.
// ----------------------------------------------------------------------------
module aabb_vertex_accumulator
    import aabb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vertex_x, vertex_y, vertex_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // first_vertex
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // low_x, low_y, low_z, high_x, high_y, high_z, center_x, center_y,
    // center_z, radius
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    aabb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    aabb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (s_axis_tvalid && w_in_ready),
        .i_first     (s_axis_tuser),
        .i_vertex    (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = w_in_ready;

endmodule
